// ----- hdl/wlcf_pkg.sv -----
package wlcf_pkg;

	localparam int unsigned SETS_DEF       = 1024;
	localparam int unsigned WAYS_DEF       = 16;
	localparam int unsigned LINE_SIZE_DEF  = 64;
	localparam int unsigned ADDR_BITS_DEF  = 48;
	localparam int unsigned FIELD_BITS     = 48;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_OUT1,
		ST_OUT2
	} state_t;

	function automatic int unsigned flog2(input int unsigned v);
		int unsigned r;
		int unsigned x;
		r = 0;
		x = v;
		while (x > 1) begin
			x = x >> 1;
			r = r + 1;
		end
		return r;
	endfunction

endpackage

// ----- hdl/wlcf_ram.sv -----
module wlcf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/writeback_lru_cache_filter_top.sv -----
// A hit gives no beat; a miss gives its fill beat and, if the evicted way is dirty, a
// writeback beat after it. A pass-through beat is offered in the cycle after acceptance.
// One access is processed at a time: the set row is read, updated and written back in
// the set memory before the next access is accepted; a miss also waits for its beats to leave.
// Reset is asynchronous and active low; afterwards the block clears the set memory
// one set per cycle, through every set, before it accepts the first access.
module writeback_lru_cache_filter_top #(
	parameter int unsigned SETS       = wlcf_pkg::SETS_DEF,
	parameter int unsigned WAYS       = wlcf_pkg::WAYS_DEF,
	parameter int unsigned LINE_SIZE  = wlcf_pkg::LINE_SIZE_DEF,
	parameter int unsigned ADDR_BITS  = wlcf_pkg::ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // line_addr[47:0], store[48], zero fill
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [55:0] m_tdata,  // mem_addr[47:0], mem_write[48], zero fill
	output logic        m_tlast
);

	localparam int unsigned FB    = wlcf_pkg::FIELD_BITS;
	localparam int unsigned OFFB  = wlcf_pkg::flog2(LINE_SIZE);
	localparam int unsigned IDXB  = wlcf_pkg::flog2(SETS);
	localparam int unsigned NSETS = 1 << IDXB;
	localparam int unsigned SB    = (IDXB > 0) ? IDXB : 1;
	localparam int unsigned AB    = (ADDR_BITS < FB) ? ADDR_BITS : FB;
	localparam int unsigned TB    = (AB > OFFB + IDXB) ? AB - OFFB - IDXB : 1;
	localparam int unsigned RB    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned WAYB  = TB + 2 + RB;
	localparam int unsigned ROWB  = WAYS * WAYB;

	typedef struct packed {
		logic [TB-1:0] tag;
		logic          valid;
		logic          dirty;
		logic [RB-1:0] age;
	} way_t;

	wlcf_pkg::state_t state_q, state_d;
	logic          en_q;
	logic [SB-1:0] clr_q;
	logic [AB-1:0] addr_q;
	logic          wr_q;
	logic [FB-1:0] wb_q;
	logic          two_q;

	logic          we;
	logic [SB-1:0] waddr, raddr;
	way_t [WAYS-1:0] row_r, row_w;
	logic [ROWB-1:0] rdata;
	logic [AB-1:0]   in_addr;
	logic [SB-1:0]   set_q;
	logic [TB-1:0]   tag_q;

	logic            hit, any_inv, dirty_ev;
	logic [RB-1:0]   hw, iw, vw, sel, sel_age;
	logic [FB-1:0]   aligned, wb_d;

	assign in_addr = s_tdata[AB-1:0];
	assign set_q   = (IDXB > 0) ? SB'(addr_q >> OFFB) : '0;
	assign tag_q   = TB'(addr_q >> (OFFB + IDXB));
	assign aligned = FB'((addr_q >> OFFB) << OFFB);
	assign row_r   = rdata;

	wlcf_ram #(.WIDTH(ROWB), .DEPTH(NSETS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(row_w), .raddr(raddr), .rdata(rdata)
	);

	always_comb begin
		logic [RB-1:0] best;
		hit = 1'b0;
		hw = '0;
		any_inv = 1'b0;
		iw = '0;
		vw = '0;
		best = row_r[0].age;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (row_r[i].valid && row_r[i].tag == tag_q) begin
				hit = 1'b1;
				hw = RB'(i);
			end
			if (!row_r[i].valid) begin
				any_inv = 1'b1;
				iw = RB'(i);
			end
		end
		for (int i = 1; i < WAYS; i++) begin
			if (row_r[i].age > best) begin
				best = row_r[i].age;
				vw = RB'(i);
			end
		end
		sel = hit ? hw : (any_inv ? iw : vw);
		sel_age = row_r[sel].age;
		dirty_ev = !hit && !any_inv && row_r[vw].dirty;
		wb_d = FB'(((AB'(row_r[vw].tag) << (OFFB + IDXB)) | (AB'(set_q) << OFFB)));
		row_w = row_r;
		for (int i = 0; i < WAYS; i++) begin
			if (RB'(i) != sel && row_r[i].valid && (!hit && any_inv || row_r[i].age < sel_age)) begin
				row_w[i].age = row_r[i].age + 1'b1;
			end
		end
		row_w[sel].age = '0;
		row_w[sel].valid = 1'b1;
		if (hit) begin
			row_w[sel].dirty = row_r[sel].dirty | wr_q;
		end else begin
			row_w[sel].dirty = wr_q;
			row_w[sel].tag = tag_q;
		end
		if (state_q == wlcf_pkg::ST_CLEAR) begin
			row_w = '0;
		end
	end

	assign we    = (state_q == wlcf_pkg::ST_CLEAR) || (state_q == wlcf_pkg::ST_LOOK);
	assign waddr = (state_q == wlcf_pkg::ST_CLEAR) ? clr_q : set_q;
	assign raddr = (IDXB > 0) ? SB'(in_addr >> OFFB) : '0;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wlcf_pkg::ST_CLEAR: begin
				if (clr_q == SB'(NSETS - 1)) state_d = wlcf_pkg::ST_IDLE;
			end
			wlcf_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = en_q ? wlcf_pkg::ST_LOOK : wlcf_pkg::ST_OUT1;
			end
			wlcf_pkg::ST_LOOK: begin
				state_d = hit ? wlcf_pkg::ST_IDLE : wlcf_pkg::ST_OUT1;
			end
			wlcf_pkg::ST_OUT1: begin
				if (m_tready) state_d = two_q ? wlcf_pkg::ST_OUT2 : wlcf_pkg::ST_IDLE;
			end
			wlcf_pkg::ST_OUT2: begin
				if (m_tready) state_d = wlcf_pkg::ST_IDLE;
			end
			default: state_d = wlcf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == wlcf_pkg::ST_IDLE);
		cfg_ready = (state_q == wlcf_pkg::ST_IDLE);
		m_tvalid  = (state_q == wlcf_pkg::ST_OUT1) || (state_q == wlcf_pkg::ST_OUT2);
		m_tdata   = '0;
		m_tlast   = 1'b1;
		if (state_q == wlcf_pkg::ST_OUT2) begin
			m_tdata[FB-1:0] = wb_q;
			m_tdata[FB]     = 1'b1;
		end else begin
			m_tdata[FB-1:0] = aligned;
			m_tdata[FB]     = wr_q;
			m_tlast         = !two_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wlcf_pkg::ST_CLEAR;
			en_q    <= 1'b1;
			clr_q   <= '0;
			two_q   <= 1'b0;
			wr_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == wlcf_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg_valid && cfg_ready) en_q <= cfg_data;
			if (s_tvalid && s_tready) begin
				wr_q  <= s_tdata[FB];
				two_q <= 1'b0;
			end
			if (state_q == wlcf_pkg::ST_LOOK) begin
				two_q <= dirty_ev;
				wr_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) addr_q <= in_addr;
		if (state_q == wlcf_pkg::ST_LOOK) wb_q <= wb_d;
	end

endmodule
